>>> rtl/pts_pkg.sv
// ---------------------------------------------------------------------------
// Polyphonic tone synthesiser package
// Shared types, register codes, sizes and the semitone ratio table.
// ---------------------------------------------------------------------------
package pts_pkg;

  localparam int VOICES_DEF       = 16;
  localparam int EVENTS_DEF       = 256;
  localparam int SINE_ENTRIES_DEF = 1024;
  localparam int QUEUE_DEPTH      = 4;

  localparam int PADDR_W = 3;

  typedef enum logic {
    REG_BASE_PHASE_STEP = 1'b0,
    REG_BEAT_STEP       = 1'b1
  } reg_idx_t;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_APPEND = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    WAVE_SQUARE   = 3'd0,
    WAVE_SINE     = 3'd1,
    WAVE_TRIANGLE = 3'd2,
    WAVE_SAWTOOTH = 3'd3,
    WAVE_NOISE    = 3'd4
  } wave_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EV_RD,
    S_EV_CHK,
    S_EV_WR,
    S_V_RD,
    S_V_UPD,
    S_V_AMP,
    S_V_ACC,
    S_EMIT
  } state_t;

  // One request as it travels from the front end to the sequencer.
  typedef struct packed {
    op_t         op;
    logic        advance;
    logic [31:0] beat;
    logic [25:0] note;   // semitone | volume << 7 | waveform << 23
    logic [23:0] len;
  } item_t;

  typedef struct packed {
    logic [31:0] start;
    logic [25:0] note;
    logic [23:0] len;
  } event_t;

  typedef struct packed {
    logic [31:0]        phase;
    logic [31:0]        step;
    logic signed [40:0] left;
    logic [18:0]        gain_wave;
    logic signed [15:0] prev_amp;
    logic               crossing;
  } voice_t;

  localparam logic [31:0] BASE_PHASE_STEP_RST = 32'd39370533;
  localparam logic [31:0] BEAT_STEP_RST       = 32'd178957;
  localparam logic [31:0] LFSR_MASK           = 32'h80200003;

  function automatic logic [16:0] semitone_ratio(input logic [3:0] k);
    logic [16:0] r;
    case (k)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd69433;
      4'd2:    r = 17'd73562;
      4'd3:    r = 17'd77936;
      4'd4:    r = 17'd82570;
      4'd5:    r = 17'd87480;
      4'd6:    r = 17'd92682;
      4'd7:    r = 17'd98193;
      4'd8:    r = 17'd104032;
      4'd9:    r = 17'd110218;
      4'd10:   r = 17'd116772;
      4'd11:   r = 17'd123716;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/pts_front.sv
// ---------------------------------------------------------------------------
// Front end
// Takes requests from the input channel, classifies and packs them into
// queue items, holding one item while the queue is full.
// ---------------------------------------------------------------------------
module pts_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_op,
  input  logic                in_advance_song,
  input  logic [31:0]         in_event_beat,
  input  logic signed [6:0]   in_semitone,
  input  logic [15:0]         in_note_volume,
  input  logic [2:0]          in_waveform,
  input  logic [23:0]         in_note_length,
  output logic                push,
  output pts_pkg::item_t      push_item,
  input  logic                q_full
);
  import pts_pkg::*;

  logic  hold_r, hold_nxt;
  item_t item_r, item_nxt;
  logic  take;

  assign push      = hold_r && !q_full;
  assign push_item = item_r;
  assign in_stall  = hold_r && q_full;
  assign take      = in_valid && !in_stall;

  always_comb begin
    hold_nxt = hold_r;
    item_nxt = item_r;
    if (push) begin
      hold_nxt = 1'b0;
    end
    if (take) begin
      hold_nxt = 1'b1;
      item_nxt.op = op_t'(in_op);
      // Only ticks look at the advance flag; appends carry the event.
      item_nxt.advance = (op_t'(in_op) == OP_TICK) && in_advance_song;
      item_nxt.beat    = in_event_beat;
      item_nxt.note    = {in_waveform, in_note_volume, in_semitone};
      item_nxt.len     = in_note_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

>>> rtl/pts_queue.sv
// ---------------------------------------------------------------------------
// Request queue
// A short first-in first-out buffer between the front end and the sequencer.
// ---------------------------------------------------------------------------
module pts_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pts_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output pts_pkg::item_t head
);
  import pts_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  item_t         mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == (AW+1)'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

endmodule

>>> rtl/pts_engine.sv
// ---------------------------------------------------------------------------
// Sequencer and voice engine
// Stores note events, starts due notes on advancing ticks, walks every voice
// through a shared update unit and mixes the sample into the output register.
// ---------------------------------------------------------------------------
module pts_engine #(
  parameter int VOICES       = pts_pkg::VOICES_DEF,
  parameter int EVENTS       = pts_pkg::EVENTS_DEF,
  parameter int SINE_ENTRIES = pts_pkg::SINE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  pts_pkg::item_t     q_head,
  output logic               q_pop,
  input  logic [31:0]        base_phase_step,
  input  logic [31:0]        beat_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_mix_sample,
  output logic               out_accepted,
  output logic [4:0]         out_voices_busy
);
  import pts_pkg::*;

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int EW = (EVENTS > 1) ? $clog2(EVENTS) : 1;
  localparam int EC = $clog2(EVENTS + 1);
  localparam int VC = $clog2(VOICES + 1);
  localparam int SW = (SINE_ENTRIES > 1) ? $clog2(SINE_ENTRIES) : 1;
  localparam int SUM_W = 34 + VW + 1;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [15:0] sine_rom_t [SINE_ENTRIES];

  function automatic logic signed [15:0] sine_entry(input int idx);
    logic [63:0] p, r, a, a2, t, v;
    logic [1:0]  q;
    p = (64'(idx) << 32) / SINE_ENTRIES;
    q = p[31:30];
    r = p & (Q30_ONE - 64'd1);
    if (q[0]) begin
      r = Q30_ONE - r;
    end
    a  = (r * HALF_PI_Q30) >> 30;
    a2 = (a * a) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((a2 * t) >> 30) / 110;
    t  = Q30_ONE - ((a2 * t) >> 30) / 72;
    t  = Q30_ONE - ((a2 * t) >> 30) / 42;
    t  = Q30_ONE - ((a2 * t) >> 30) / 20;
    t  = Q30_ONE - ((a2 * t) >> 30) / 6;
    v  = (((a * t) >> 30) + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return q[1] ? -16'(v) : 16'(v);
  endfunction

  function automatic sine_rom_t sine_rom_init();
    sine_rom_t rom;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      rom[i] = sine_entry(i);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = sine_rom_init();

  // Storage
  event_t ev_mem [EVENTS];
  event_t ev_q;
  voice_t voice_mem [VOICES];
  voice_t vq;
  logic signed [15:0] sine_q;

  state_t state_r, state_nxt;
  logic [EC-1:0]     ev_cnt_r, ev_cnt_nxt, next_ev_r, next_ev_nxt;
  logic [47:0]       beat_r, beat_nxt;
  logic [VOICES-1:0] busy_r, busy_nxt;
  logic [VC-1:0]     nbusy_r, nbusy_nxt;
  logic [31:0]       lfsr_r, lfsr_nxt;
  logic [VW-1:0]     v_r, v_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;

  // Request in flight: append or tick, and whether it was taken.
  logic          app_r, app_nxt;
  logic          ok_r, ok_nxt;

  // Note start datapath
  logic [48:0]   prod_r, prod_nxt;
  logic [4:0]    sh_r, sh_nxt;
  logic [23:0]   len_r, len_nxt;
  logic [18:0]   gw_r, gw_nxt;
  logic [VW-1:0] free_r, free_nxt;
  logic          free_ok_r, free_ok_nxt;

  // Voice update datapath
  logic [31:0]        ph_r, ph_nxt;
  logic signed [40:0] left_r, left_nxt;
  logic [SW-1:0]      sidx;
  logic signed [32:0] mul_r, mul_nxt;

  // Output register
  logic              ov_r, ov_nxt;
  logic signed [15:0] omix_r, omix_nxt;
  logic              oacc_r, oacc_nxt;
  logic [4:0]        obusy_r, obusy_nxt;

  // Memory write controls
  logic          ev_we;
  logic          vm_we;
  logic [VW-1:0] vm_waddr;
  voice_t        vm_wdata;

  logic          v_last;
  logic [VW-1:0] free_idx;
  logic          free_any;
  logic [7:0]    tval;
  logic [3:0]    oct_q;
  logic [18:0]   tq;
  logic [48:0]   rounded;
  logic signed [41:0] nl;
  logic signed [16:0] tri_a;
  logic signed [15:0] amp;
  logic [31:0]   lfsr_step;
  logic [2:0]    wave;
  logic signed [SUM_W-1:0] mix_full;

  assign out_valid       = ov_r;
  assign out_mix_sample  = omix_r;
  assign out_accepted    = oacc_r;
  assign out_voices_busy = obusy_r;

  assign v_last = (v_r == VW'(VOICES - 1));

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_any = 1'b1;
        free_idx = VW'(i);
      end
    end
  end

  // Semitone split: t/12 by reciprocal, exact for the eight-bit range used.
  assign tval  = 8'(signed'(ev_q.note[6:0])) + 8'd72;
  assign tq    = 19'(tval) * 19'd171;
  assign oct_q = tq[14:11];

  // The sine table is addressed with the new phase so that its registered
  // output is ready when the amplitude is formed.
  assign rounded   = prod_r + (49'd1 << (sh_r - 5'd1));
  assign sidx      = SW'((64'(ph_nxt) * 64'(SINE_ENTRIES)) >> 32);
  assign lfsr_step = (lfsr_r >> 1) ^ ({32{lfsr_r[0]}} & LFSR_MASK);
  assign wave      = vq.gain_wave[18:16];
  assign tri_a     = 17'sd32768 - 17'(ph_r[31:15]);

  always_comb begin
    case (wave)
      WAVE_SQUARE:   amp = (ph_r > 32'h80000000) ? 16'sd32767 : 16'sh8000;
      WAVE_SINE:     amp = sine_q;
      WAVE_TRIANGLE: begin
        if (ph_r > 32'h80000000) begin
          amp = 16'(18'(ph_r[31:15]) - 18'd98304);
        end else begin
          amp = (tri_a > 17'sd32767) ? 16'sd32767 : 16'(tri_a);
        end
      end
      WAVE_SAWTOOTH: amp = {~ph_r[31], ph_r[30:16]};
      WAVE_NOISE:    amp = lfsr_step[31:16];
      default:       amp = '0;
    endcase
  end

  assign nl       = 42'(vq.left) - 42'(beat_step);
  assign mix_full = (sum_r + SUM_W'(16384)) >>> 15;

  always_comb begin
    state_nxt   = state_r;
    ev_cnt_nxt  = ev_cnt_r;
    next_ev_nxt = next_ev_r;
    beat_nxt    = beat_r;
    busy_nxt    = busy_r;
    nbusy_nxt   = nbusy_r;
    lfsr_nxt    = lfsr_r;
    v_nxt       = v_r;
    sum_nxt     = sum_r;
    app_nxt     = app_r;
    ok_nxt      = ok_r;
    prod_nxt    = prod_r;
    sh_nxt      = sh_r;
    len_nxt     = len_r;
    gw_nxt      = gw_r;
    free_nxt    = free_r;
    free_ok_nxt = free_ok_r;
    ph_nxt      = ph_r;
    left_nxt    = left_r;
    mul_nxt     = mul_r;
    ov_nxt      = ov_r;
    omix_nxt    = omix_r;
    oacc_nxt    = oacc_r;
    obusy_nxt   = obusy_r;
    q_pop       = 1'b0;
    ev_we       = 1'b0;
    vm_we       = 1'b0;
    vm_waddr    = v_r;
    vm_wdata    = vq;

    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (q_not_empty) begin
          q_pop   = 1'b1;
          app_nxt = (q_head.op == OP_APPEND);
          if (q_head.op == OP_APPEND) begin
            ok_nxt = 1'b0;
            if (ev_cnt_r < EC'(EVENTS)) begin
              ev_we      = 1'b1;
              ev_cnt_nxt = ev_cnt_r + 1'b1;
              ok_nxt     = 1'b1;
            end
            state_nxt = S_EMIT;
          end else begin
            sum_nxt = '0;
            v_nxt   = '0;
            ok_nxt  = 1'b1;
            if (q_head.advance) begin
              beat_nxt  = beat_r + 48'(beat_step);
              state_nxt = S_EV_RD;
            end else begin
              state_nxt = S_V_RD;
            end
          end
        end
      end
      // Event memory is read at next_ev_r; its registered data is ready in S_EV_CHK.
      S_EV_RD: begin
        state_nxt = (next_ev_r < ev_cnt_r) ? S_EV_CHK : S_V_RD;
      end
      S_EV_CHK: begin
        if (beat_r < {ev_q.start, 16'd0}) begin
          state_nxt = S_V_RD;
        end else begin
          prod_nxt    = 49'(base_phase_step) *
                        49'(semitone_ratio(4'(tval - 8'(oct_q) * 8'd12)));
          sh_nxt      = 5'd22 - 5'(oct_q);
          len_nxt     = ev_q.len;
          gw_nxt      = ev_q.note[25:7];
          free_nxt    = free_idx;
          free_ok_nxt = free_any;
          next_ev_nxt = next_ev_r + 1'b1;
          state_nxt   = S_EV_WR;
        end
      end
      S_EV_WR: begin
        if (free_ok_r) begin
          vm_we              = 1'b1;
          vm_waddr           = free_r;
          vm_wdata.phase     = '0;
          vm_wdata.step      = 32'(rounded >> sh_r);
          vm_wdata.left      = 41'({len_r, 16'd0});
          vm_wdata.gain_wave = gw_r;
          vm_wdata.prev_amp  = '0;
          vm_wdata.crossing  = 1'b0;
          busy_nxt[free_r]   = 1'b1;
          nbusy_nxt          = nbusy_r + 1'b1;
        end
        state_nxt = S_EV_RD;
      end
      // Voice memory is read at v_r; idle voices are skipped.
      S_V_RD: begin
        if (busy_r[v_r]) begin
          state_nxt = S_V_UPD;
        end else if (v_last) begin
          state_nxt = S_EMIT;
        end else begin
          v_nxt = v_r + 1'b1;
        end
      end
      S_V_UPD: begin
        ph_nxt = vq.phase + vq.step;
        if (vq.crossing && vq.left < 0) begin
          busy_nxt[v_r] = 1'b0;
          nbusy_nxt     = nbusy_r - 1'b1;
          if (v_last) begin
            state_nxt = S_EMIT;
          end else begin
            v_nxt     = v_r + 1'b1;
            state_nxt = S_V_RD;
          end
        end else begin
          left_nxt  = (nl < -42'sd1099511627776) ? -41'sd1099511627776 : 41'(nl);
          state_nxt = S_V_AMP;
        end
      end
      S_V_AMP: begin
        if (wave == WAVE_NOISE) begin
          lfsr_nxt = lfsr_step;
        end
        vm_we             = 1'b1;
        vm_wdata.phase    = ph_r;
        vm_wdata.left     = left_r;
        vm_wdata.prev_amp = amp;
        vm_wdata.crossing = (vq.prev_amp == 0) || (amp == 0) ||
                            (vq.prev_amp[15] != amp[15]);
        mul_nxt   = 33'(amp) * 33'(signed'({1'b0, vq.gain_wave[15:0]}));
        state_nxt = S_V_ACC;
      end
      S_V_ACC: begin
        sum_nxt = sum_r + SUM_W'(mul_r);
        if (v_last) begin
          state_nxt = S_EMIT;
        end else begin
          v_nxt     = v_r + 1'b1;
          state_nxt = S_V_RD;
        end
      end
      // The result register is only loaded once the previous result has left.
      S_EMIT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          oacc_nxt  = ok_r;
          obusy_nxt = 5'(nbusy_r);
          if (app_r) begin
            omix_nxt = '0;
          end else if (mix_full > SUM_W'(32767)) begin
            omix_nxt = 16'sd32767;
          end else if (mix_full < -SUM_W'(32768)) begin
            omix_nxt = 16'sh8000;
          end else begin
            omix_nxt = 16'(mix_full);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ev_cnt_r  <= '0;
      next_ev_r <= '0;
      beat_r    <= '0;
      busy_r    <= '0;
      nbusy_r   <= '0;
      lfsr_r    <= 32'd1;
      ov_r      <= 1'b0;
      app_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ev_cnt_r  <= ev_cnt_nxt;
      next_ev_r <= next_ev_nxt;
      beat_r    <= beat_nxt;
      busy_r    <= busy_nxt;
      nbusy_r   <= nbusy_nxt;
      lfsr_r    <= lfsr_nxt;
      ov_r      <= ov_nxt;
      app_r     <= app_nxt;
    end
    v_r       <= v_nxt;
    sum_r     <= sum_nxt;
    ok_r      <= ok_nxt;
    prod_r    <= prod_nxt;
    sh_r      <= sh_nxt;
    len_r     <= len_nxt;
    gw_r      <= gw_nxt;
    free_r    <= free_nxt;
    free_ok_r <= free_ok_nxt;
    ph_r      <= ph_nxt;
    left_r    <= left_nxt;
    mul_r     <= mul_nxt;
    omix_r    <= omix_nxt;
    oacc_r    <= oacc_nxt;
    obusy_r   <= obusy_nxt;
  end

  always_ff @(posedge clk) begin
    if (ev_we) begin
      ev_mem[ev_cnt_r[EW-1:0]] <= '{start: q_head.beat, note: q_head.note, len: q_head.len};
    end
    ev_q <= ev_mem[next_ev_r[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (vm_we) begin
      voice_mem[vm_waddr] <= vm_wdata;
    end
    vq <= voice_mem[v_r];
  end

  always_ff @(posedge clk) begin
    sine_q <= SINE_ROM[sidx];
  end

  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    nbusy_r <= VC'(VOICES))
    else $error("busy voice count exceeds the number of voices");

  a_next_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    next_ev_r <= ev_cnt_r)
    else $error("event read pointer passed the stored count");

  a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EV_WR && free_ok_r) |-> !busy_r[free_r])
    else $error("note started in a voice that is already sounding");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> ov_r && $stable(omix_r) && $stable(oacc_r) &&
                            $stable(obusy_r))
    else $error("stalled result was overwritten");

endmodule

>>> rtl/polyphonic_tone_synth_top.sv
// ---------------------------------------------------------------------------
// Polyphonic tone synthesiser, top level
// Note event store, tempo sequencer and oscillator bank with a mixed output.
// ---------------------------------------------------------------------------
// Requests enter on the in_ channel (valid/stall); each gives exactly one
// result on the out_ channel. An append request stores a note event when the
// store has room; a tick request optionally advances the song (starting the
// notes then due) and then produces one mixed sample. Configuration is
// written through the APB-style port (base phase step at 0x0, beat step at
// 0x4); the user must write it only while the block is idle, as the block
// itself does not enforce this. The shared voice update unit visits the
// voices one after another. Requests are worked on one at a time. A short
// request queue lets new requests be taken while the sequencer works. Reset
// clears the event count, song position, voices and noise register; the
// event store itself is not cleared. While the receiver stalls, the result
// is held and the queue fills before in_stall rises.
// ---------------------------------------------------------------------------
module polyphonic_tone_synth_top #(
  parameter int VOICES       = pts_pkg::VOICES_DEF,
  parameter int EVENTS       = pts_pkg::EVENTS_DEF,
  parameter int SINE_ENTRIES = pts_pkg::SINE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic                        in_advance_song,
  input  logic [31:0]                 in_event_beat,
  input  logic signed [6:0]           in_semitone,
  input  logic [15:0]                 in_note_volume,
  input  logic [2:0]                  in_waveform,
  input  logic [23:0]                 in_note_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [15:0]          out_mix_sample,
  output logic                        out_accepted,
  output logic [4:0]                  out_voices_busy,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pts_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import pts_pkg::*;

  logic [31:0] base_r, base_nxt, beat_step_r, beat_step_nxt;
  logic        push, q_full, q_pop, q_not_empty;
  item_t       push_item, q_head;
  reg_idx_t    ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[2]);
  assign prdata = (ridx == REG_BEAT_STEP) ? beat_step_r : base_r;

  always_comb begin
    base_nxt      = base_r;
    beat_step_nxt = beat_step_r;
    if (psel && penable && pwrite) begin
      case (ridx)
        REG_BASE_PHASE_STEP: base_nxt      = pwdata;
        REG_BEAT_STEP:       beat_step_nxt = pwdata;
        default:             base_nxt      = base_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= BASE_PHASE_STEP_RST;
      beat_step_r <= BEAT_STEP_RST;
    end else begin
      base_r      <= base_nxt;
      beat_step_r <= beat_step_nxt;
    end
  end

  pts_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_advance_song, .in_event_beat,
    .in_semitone, .in_note_volume, .in_waveform, .in_note_length,
    .push, .push_item, .q_full
  );

  pts_queue u_queue (
    .clk, .rst_n, .push, .push_item, .full(q_full), .pop(q_pop),
    .not_empty(q_not_empty), .head(q_head)
  );

  pts_engine #(
    .VOICES(VOICES), .EVENTS(EVENTS), .SINE_ENTRIES(SINE_ENTRIES)
  ) u_engine (
    .clk, .rst_n, .q_not_empty, .q_head, .q_pop,
    .base_phase_step(base_r), .beat_step(beat_step_r),
    .out_valid, .out_stall, .out_mix_sample, .out_accepted, .out_voices_busy
  );

endmodule

>>> tb/polyphonic_tone_synth_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Polyphonic tone synthesiser result checker
// Watches the request and result channels and the register port, predicts each result
// from its own model of the sequencer and voices, and compares field by field.
// ---------------------------------------------------------------------------
module polyphonic_tone_synth_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_op,
  input  logic                        in_advance_song,
  input  logic [31:0]                 in_event_beat,
  input  logic signed [6:0]           in_semitone,
  input  logic [15:0]                 in_note_volume,
  input  logic [2:0]                  in_waveform,
  input  logic [23:0]                 in_note_length,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic signed [15:0]          out_mix_sample,
  input  logic                        out_accepted,
  input  logic [4:0]                  out_voices_busy,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pts_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output int                          fail_count,
  output int                          pending
);
  import pts_pkg::*;

  localparam int NV = VOICES_DEF;
  localparam int NE = EVENTS_DEF;
  localparam longint LEFT_MIN = -(64'sd1 <<< 40);

  typedef struct packed {
    logic signed [15:0] mix;
    logic               acc;
    logic [4:0]         busy;
  } mix_result_t;

  mix_result_t expected_mix[$];

  logic [31:0] base_step, beat_step;
  logic [31:0] ev_start[NE];
  logic [25:0] ev_note[NE];
  logic [23:0] ev_len[NE];
  int          ev_count, ev_next;
  logic [47:0] song_pos;
  logic        v_busy[NV];
  logic [31:0] v_phase[NV];
  logic [31:0] v_step[NV];
  longint      v_left[NV];
  logic [18:0] v_gw[NV];
  int          v_prev[NV];
  logic        v_cross[NV];
  logic [31:0] lfsr;
  int          sine_lut[SINE_ENTRIES_DEF];

  function automatic int sine_value(int idx);
    longint unsigned p, r, a, a2, t, v;
    int q;
    p = (longint'(idx) << 32) / SINE_ENTRIES_DEF;
    q = int'((p >> 30) & 3);
    r = p & ((64'd1 << 30) - 1);
    if (q[0]) r = (64'd1 << 30) - r;
    a = (r * 64'd1686629713) >> 30;
    a2 = (a * a) >> 30;
    t = 64'd1 << 30;
    t = (64'd1 << 30) - ((a2 * t) >> 30) / 110;
    t = (64'd1 << 30) - ((a2 * t) >> 30) / 72;
    t = (64'd1 << 30) - ((a2 * t) >> 30) / 42;
    t = (64'd1 << 30) - ((a2 * t) >> 30) / 20;
    t = (64'd1 << 30) - ((a2 * t) >> 30) / 6;
    v = (((a * t) >> 30) + 16384) >> 15;
    if (v > 32767) v = 32767;
    return (q >= 2) ? -int'(v) : int'(v);
  endfunction

  function automatic logic [31:0] note_step(logic [6:0] raw);
    int s, t, oct, k, sh;
    longint unsigned prod;
    s = $signed(raw);
    t = s + 72;
    oct = t / 12 - 6;
    k = t % 12;
    sh = 16 - oct;
    prod = longint'(base_step) * semitone_ratio(k[3:0]) + (64'd1 << (sh - 1));
    return 32'(prod >> sh);
  endfunction

  function automatic int voice_amp(logic [2:0] w, logic [31:0] ph);
    int a;
    case (w)
      WAVE_SQUARE:   return (ph > 32'h80000000) ? 32767 : -32768;
      WAVE_SINE:     return sine_lut[ph[31:22]];
      WAVE_TRIANGLE: begin
        if (ph > 32'h80000000) return int'(ph >> 15) - 98304;
        a = 32768 - int'(ph >> 15);
        return (a > 32767) ? 32767 : a;
      end
      WAVE_SAWTOOTH: return int'(ph >> 16) - 32768;
      WAVE_NOISE:    begin
        lfsr = (lfsr >> 1) ^ (lfsr[0] ? LFSR_MASK : 32'd0);
        return $signed(lfsr[31:16]);
      end
      default:       return 0;
    endcase
  endfunction

  function automatic logic [4:0] busy_voices();
    int n;
    n = 0;
    for (int v = 0; v < NV; v++) n += v_busy[v];
    return n[4:0];
  endfunction

  task automatic start_note(int e);
    for (int v = 0; v < NV; v++) begin
      if (!v_busy[v]) begin
        v_busy[v] = 1'b1;
        v_phase[v] = '0;
        v_step[v] = note_step(ev_note[e][6:0]);
        v_left[v] = longint'(ev_len[e]) << 16;
        v_gw[v] = ev_note[e][25:7];
        v_prev[v] = 0;
        v_cross[v] = 1'b0;
        return;
      end
    end
  endtask

  task automatic predict_request();
    mix_result_t r;
    longint sum, nl, m;
    int amp;
    if (in_op == OP_APPEND) begin
      r.acc = 1'b0;
      if (ev_count < NE) begin
        ev_start[ev_count] = in_event_beat;
        ev_note[ev_count] = {in_waveform, in_note_volume, in_semitone};
        ev_len[ev_count] = in_note_length;
        ev_count++;
        r.acc = 1'b1;
      end
      r.mix = '0;
      r.busy = busy_voices();
      expected_mix.insert(expected_mix.size(), r);
      return;
    end
    if (in_advance_song) begin
      song_pos = song_pos + beat_step;
      while (ev_next < ev_count) begin
        if ({16'd0, song_pos} < ({32'd0, ev_start[ev_next]} << 16)) break;
        start_note(ev_next);
        ev_next++;
      end
    end
    for (int v = 0; v < NV; v++) begin
      if (!v_busy[v]) continue;
      v_phase[v] += v_step[v];
      if (v_cross[v] && v_left[v] < 0) v_busy[v] = 1'b0;
      else begin
        nl = v_left[v] - longint'(beat_step);
        v_left[v] = (nl < LEFT_MIN) ? LEFT_MIN : nl;
      end
    end
    sum = 0;
    for (int v = 0; v < NV; v++) begin
      if (!v_busy[v]) continue;
      amp = voice_amp(v_gw[v][18:16], v_phase[v]);
      v_cross[v] = (longint'(v_prev[v]) * amp) <= 0;
      v_prev[v] = amp;
      sum += longint'(amp) * longint'(v_gw[v][15:0]);
    end
    sum += 16384;
    m = sum >>> 15;
    if (m > 32767) m = 32767;
    if (m < -32768) m = -32768;
    r.mix = m[15:0];
    r.acc = 1'b1;
    r.busy = busy_voices();
    expected_mix.insert(expected_mix.size(), r);
  endtask

  initial begin
    for (int i = 0; i < SINE_ENTRIES_DEF; i++) sine_lut[i] = sine_value(i);
  end

  always @(posedge clk) begin
    mix_result_t e;
    if (!rst_n) begin
      base_step = BASE_PHASE_STEP_RST;
      beat_step = BEAT_STEP_RST;
      ev_count = 0;
      ev_next = 0;
      song_pos = '0;
      lfsr = 32'd1;
      for (int v = 0; v < NV; v++) begin
        v_busy[v] = 1'b0; v_phase[v] = '0; v_step[v] = '0; v_left[v] = 0;
        v_gw[v] = '0; v_prev[v] = 0; v_cross[v] = 1'b0;
      end
      expected_mix.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[PADDR_W-1:2] == REG_BASE_PHASE_STEP) base_step = pwdata;
        else if (paddr[PADDR_W-1:2] == REG_BEAT_STEP) beat_step = pwdata;
      end
      if (out_valid && !out_stall) begin
        if (expected_mix.size() == 0) begin
          $display("%0t: result with none expected: mix %0d acc %0d busy %0d",
                   $time, out_mix_sample, out_accepted, out_voices_busy);
          fail_count++;
        end else begin
          e = expected_mix.pop_front();
          if (out_mix_sample !== e.mix || out_accepted !== e.acc ||
              out_voices_busy !== e.busy) begin
            $display("%0t: mismatch: expected mix %0d acc %0d busy %0d, got %0d %0d %0d",
                     $time, e.mix, e.acc, e.busy,
                     out_mix_sample, out_accepted, out_voices_busy);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) predict_request();
    end
    pending = expected_mix.size();
  end

endmodule

>>> tb/polyphonic_tone_synth_top_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Polyphonic tone synthesiser testbench
// Directed and random note events and ticks under varied flow control and
// tempo/pitch settings; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module polyphonic_tone_synth_top_test;
  import pts_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_stall;
  logic in_op = OP_TICK, in_advance_song = 1'b0;
  logic [31:0] in_event_beat = '0;
  logic signed [6:0] in_semitone = '0;
  logic [15:0] in_note_volume = '0;
  logic [2:0] in_waveform = '0;
  logic [23:0] in_note_length = '0;
  logic out_valid, out_stall = 1'b0;
  logic signed [15:0] out_mix_sample;
  logic out_accepted;
  logic [4:0] out_voices_busy;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  int fail_count, pending;
  int send_idle = 0, stall_pct = 0;
  bit hold_off = 1'b0;
  longint cycles = 0;
  logic [31:0] next_beat = '0;
  int appended = 0;

  always #5 clk = ~clk;

  polyphonic_tone_synth_top i_dut (.*);

  polyphonic_tone_synth_checker i_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off to fill the request queue.
  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // Valid stays high from one request to the next; it drops only while the
  // sender idles or waits for the block to drain.
  task automatic send(logic op, logic adv, logic [31:0] beat, logic signed [6:0] semi,
                      logic [15:0] vol, logic [2:0] wave, logic [23:0] len);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_advance_song <= adv;
    in_event_beat <= beat;
    in_semitone <= semi;
    in_note_volume <= vol;
    in_waveform <= wave;
    in_note_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic tick(logic adv);
    send(OP_TICK, adv, $urandom, 7'($urandom), 16'($urandom), 3'($urandom),
         24'($urandom));
  endtask

  task automatic add_note(logic [31:0] beat, logic signed [6:0] semi, logic [15:0] vol,
                          logic [2:0] wave, logic [23:0] len);
    send(OP_APPEND, 1'($urandom), beat, semi, vol, wave, len);
    appended++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed songs: notes in beat order, ticks that advance.
  task automatic random_phase(int n);
    logic signed [6:0] semi;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 20 && appended < EVENTS_DEF + 4) begin
        semi = $signed(7'($urandom_range(96))) - 7'sd48;
        if ($urandom_range(9) == 0) semi = 7'($urandom);
        if ($urandom_range(9) == 0) next_beat = $urandom;
        else next_beat = next_beat + $urandom_range(3);
        add_note(next_beat, semi,
                 ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768)),
                 ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(4)),
                 ($urandom_range(4) == 0) ? 24'($urandom) : 24'($urandom_range(200000)));
      end else begin
        tick($urandom_range(99) < 85);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fast tempo so notes start and end quickly.
    write_reg(REG_BEAT_STEP, 32'h0080_0000);
    write_reg(REG_BASE_PHASE_STEP, 32'h0100_0000);
    add_note(32'd0, -7'sd48, 16'd32768, WAVE_SQUARE, 24'd0);
    add_note(32'd0, 7'sd48, 16'hFFFF, WAVE_SINE, 24'hFFFFFF);
    add_note(32'd0, 7'sd0, 16'd0, WAVE_TRIANGLE, 24'd1);
    add_note(32'd0, 7'sd63, 16'd20000, WAVE_SAWTOOTH, 24'd50);
    add_note(32'd0, 7'sh40, 16'd30000, WAVE_NOISE, 24'd100);
    add_note(32'd1, 7'sd5, 16'd32768, 3'd7, 24'd10);
    add_note(32'd1, 7'sd12, 16'd32768, 3'd5, 24'd10);
    add_note(32'd0, -7'sd12, 16'd32768, WAVE_SQUARE, 24'd10);
    tick(1'b0);
    tick(1'b1);
    repeat (3) tick(1'b1);
    tick(1'b0);
    for (int i = 0; i < 14; i++)
      add_note(32'd2, 7'($urandom_range(96)) - 7'sd48, 16'd32768, WAVE_SQUARE, 24'd5);
    repeat (6) tick(1'b1);
    next_beat = 32'd3;
    drain();

    write_reg(REG_BEAT_STEP, 32'hFFFF_FFFF);
    write_reg(REG_BASE_PHASE_STEP, 32'hFFFF_FFFF);
    random_phase(200);
    drain();

    write_reg(REG_BEAT_STEP, 32'd0);
    write_reg(REG_BASE_PHASE_STEP, 32'd0);
    send_idle = 70;
    random_phase(150);
    drain();

    write_reg(REG_BEAT_STEP, 32'h0040_0000);
    write_reg(REG_BASE_PHASE_STEP, $urandom);
    send_idle = 0; stall_pct = 70;
    random_phase(400);
    send_idle = 16; stall_pct = 16;
    random_phase(400);
    drain();

    // Long receiver hold-off while requests keep arriving.
    send_idle = 0; stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      random_phase(60);
    join
    drain();

    write_reg(REG_BEAT_STEP, BEAT_STEP_RST);
    write_reg(REG_BASE_PHASE_STEP, BASE_PHASE_STEP_RST);
    random_phase(500);
    drain();

    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
